FILE: rtl/core/ufp_pkg.sv
// Shared types and constants for the uncompressed stereo frame packer.
// Used by the front, the command queue, the back end and the top level.
package ufp_pkg;

  // Input word kinds carried on s_tuser.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_PAD  = 1'b1;

  // Constant packet bytes.
  localparam logic [7:0] HDR_BYTE0 = 8'h20;
  localparam logic [7:0] HDR_BYTE1 = 8'h00;
  localparam logic [7:0] HDR_BYTE2 = 8'h12;
  localparam logic [7:0] HDR_BYTE3 = 8'h00;
  localparam logic [7:0] HDR_BYTE4 = 8'h00;
  localparam logic [7:0] END_BYTE  = 8'hC0;

  localparam logic [14:0] BLOCK_FRAMES_RESET = 15'd352;

  // Depth of the command queue between front and back.
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Output byte positions within the sequence produced for one frame.
  localparam logic [3:0] STEP_H0 = 4'd0;
  localparam logic [3:0] STEP_H1 = 4'd1;
  localparam logic [3:0] STEP_H2 = 4'd2;
  localparam logic [3:0] STEP_H3 = 4'd3;
  localparam logic [3:0] STEP_H4 = 4'd4;
  localparam logic [3:0] STEP_H5 = 4'd5;
  localparam logic [3:0] STEP_D0 = 4'd6;
  localparam logic [3:0] STEP_D1 = 4'd7;
  localparam logic [3:0] STEP_D2 = 4'd8;
  localparam logic [3:0] STEP_D3 = 4'd9;
  localparam logic [3:0] STEP_C0 = 4'd10;
  localparam logic [3:0] STEP_C1 = 4'd11;

  // One classified frame, as handed from the front to the back end.
  typedef struct packed {
    logic        open_pkt;
    logic        close_pkt;
    logic [7:0]  len_hi;
    logic [6:0]  pend;
    logic [15:0] left;
    logic [15:0] right;
  } cmd_t;

  // Packet state of the front, exported for checking.
  typedef struct packed {
    logic        in_packet;
    logic [14:0] frames_done;
  } front_stat_t;

endpackage

FILE: rtl/core/uncompressed_alac_frame_packer.sv
// Uncompressed stereo 16-bit packet packer. Each frame word accepted on the
// slave stream produces four bytes on the master stream, preceded by a
// six-byte header when it opens a packet and followed by a byte holding
// the low right-sample bits and the end byte 0xC0 (with tlast) when it
// completes the block, so one frame occupies 4, 6, 10 or 12 output bytes.
// The master port writes one byte per cycle while m_tready is high; a
// two-entry command queue lets frames be accepted while earlier ones are
// still being written out. The block length register is written on the
// cfg channel, saturates at MAX_BLOCK_FRAMES, and must only be changed
// while the block is idle. Depends on ufp_pkg, ufp_front, ufp_queue and
// ufp_back.
module uncompressed_alac_frame_packer #(
  parameter int unsigned MAX_BLOCK_FRAMES = 16384
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data,     // block_frames
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,      // [15:0] left_sample, [31:16] right_sample
  input  logic        s_tuser,      // operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,      // [7:0] out_byte
  output logic        m_tlast       // packet_end
);

  ufp_pkg::cmd_t        f_cmd;
  ufp_pkg::cmd_t        q_cmd;
  ufp_pkg::front_stat_t f_stat;
  logic                 f_valid;
  logic                 f_ready;
  logic                 q_valid;
  logic                 q_ready;
  logic [ufp_pkg::QCNT_W-1:0] q_fill;

  ufp_front #(
    .MAX_BLOCK_FRAMES(MAX_BLOCK_FRAMES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_left   (s_tdata[15:0]),
    .in_right  (s_tdata[31:16]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd),
    .stat      (f_stat)
  );

  ufp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd),
    .fill       (q_fill)
  );

  ufp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_end   (m_tlast)
  );

`ifndef SYNTHESIS
  // The only byte flagged as a packet end is the end byte itself.
  a_end_byte: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == ufp_pkg::END_BYTE)
    else $error("packet end flagged on a byte other than the end byte");

  // With no packet open the frame count must have been cleared.
  a_closed_count: assert property (@(posedge clk) disable iff (rst)
    !f_stat.in_packet |-> f_stat.frames_done == 15'd0)
    else $error("frame count not cleared while no packet is open");

  // The slave side stalls exactly when the command queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> q_fill == ufp_pkg::QCNT_W'(ufp_pkg::QDEPTH))
    else $error("input stalled while the command queue has room");

  // A frame accepted into an empty queue must be visible to the back end next cycle.
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && q_fill == '0 |=> q_valid)
    else $error("accepted frame did not reach the command queue");
`endif

endmodule

FILE: rtl/core/ufp_front.sv
// Front end: holds the block length register and the packet state, and
// classifies each accepted frame into a command. Depends on ufp_pkg.
module ufp_front #(
  parameter int unsigned MAX_BLOCK_FRAMES = 16384
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [14:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [15:0]        in_left,
  input  logic [15:0]        in_right,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output ufp_pkg::cmd_t      cmd,
  output ufp_pkg::front_stat_t stat
);

  localparam logic [16:0] MAX_V = 17'(MAX_BLOCK_FRAMES);

  logic [14:0] block_frames;
  logic        in_packet;
  logic [14:0] frames_done;
  logic [6:0]  pending_bits;

  logic [15:0] left_z;
  logic [15:0] right_z;
  logic [14:0] done_inc;
  logic        close_now;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && cmd_ready;

  assign left_z    = (in_op == ufp_pkg::OP_PAD) ? 16'h0000 : in_left;
  assign right_z   = (in_op == ufp_pkg::OP_PAD) ? 16'h0000 : in_right;
  assign done_inc  = (in_packet ? frames_done : 15'd0) + 15'd1;
  assign close_now = done_inc >= block_frames;

  always_comb begin
    cmd.open_pkt  = !in_packet;
    cmd.close_pkt = close_now;
    cmd.len_hi    = block_frames[14:7];
    cmd.pend      = in_packet ? pending_bits : block_frames[6:0];
    cmd.left      = left_z;
    cmd.right     = right_z;
  end

  assign stat.in_packet   = in_packet;
  assign stat.frames_done = frames_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_frames <= ufp_pkg::BLOCK_FRAMES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if ({2'b00, cfg_data} > MAX_V) begin
        block_frames <= MAX_V[14:0];
      end else begin
        block_frames <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet    <= 1'b0;
      frames_done  <= 15'd0;
      pending_bits <= 7'd0;
    end else if (accept) begin
      in_packet    <= !close_now;
      frames_done  <= close_now ? 15'd0 : done_inc;
      pending_bits <= close_now ? 7'd0 : right_z[6:0];
    end
  end

endmodule

FILE: rtl/core/ufp_queue.sv
// Short command queue that decouples the front from the back end.
// Depends on ufp_pkg for the command type and depth.
module ufp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  ufp_pkg::cmd_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output ufp_pkg::cmd_t pop_data,
  output logic [ufp_pkg::QCNT_W-1:0] fill
);

  ufp_pkg::cmd_t slots [ufp_pkg::QDEPTH];
  logic [ufp_pkg::QPTR_W-1:0] wr_ptr;
  logic [ufp_pkg::QPTR_W-1:0] rd_ptr;
  logic [ufp_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign push_ready = count != ufp_pkg::QCNT_W'(ufp_pkg::QDEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign fill       = count;

  function automatic logic [ufp_pkg::QPTR_W-1:0] bump(input logic [ufp_pkg::QPTR_W-1:0] p);
    if (p == ufp_pkg::QPTR_W'(ufp_pkg::QDEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ufp_back.sv
// Back end: takes commands from the queue and writes out their bytes one a
// cycle while out_ready allows, via a registered output stage. Depends on ufp_pkg.
module ufp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  ufp_pkg::cmd_t cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_end
);

  ufp_pkg::cmd_t cur;
  logic          busy;
  logic [3:0]    step;
  logic          load_ok;
  logic          emit;
  logic          last;
  logic          take;
  logic [7:0]    byte_sel;

  assign load_ok   = !out_valid || out_ready;
  assign emit      = busy && load_ok;
  assign last      = cur.close_pkt ? (step == ufp_pkg::STEP_C1) : (step == ufp_pkg::STEP_D3);
  assign take      = cmd_valid && (!busy || (emit && last));
  assign cmd_ready = !busy || (emit && last);

  always_comb begin
    unique case (step)
      ufp_pkg::STEP_H0: byte_sel = ufp_pkg::HDR_BYTE0;
      ufp_pkg::STEP_H1: byte_sel = ufp_pkg::HDR_BYTE1;
      ufp_pkg::STEP_H2: byte_sel = ufp_pkg::HDR_BYTE2;
      ufp_pkg::STEP_H3: byte_sel = ufp_pkg::HDR_BYTE3;
      ufp_pkg::STEP_H4: byte_sel = ufp_pkg::HDR_BYTE4;
      ufp_pkg::STEP_H5: byte_sel = cur.len_hi;
      ufp_pkg::STEP_D0: byte_sel = {cur.pend, cur.left[15]};
      ufp_pkg::STEP_D1: byte_sel = cur.left[14:7];
      ufp_pkg::STEP_D2: byte_sel = {cur.left[6:0], cur.right[15]};
      ufp_pkg::STEP_D3: byte_sel = cur.right[14:7];
      ufp_pkg::STEP_C0: byte_sel = {cur.right[6:0], 1'b1};
      ufp_pkg::STEP_C1: byte_sel = ufp_pkg::END_BYTE;
      default:          byte_sel = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= cmd;
    end
    if (emit) begin
      out_byte <= byte_sel;
      out_end  <= step == ufp_pkg::STEP_C1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      step      <= ufp_pkg::STEP_H0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        busy <= 1'b1;
        step <= cmd.open_pkt ? ufp_pkg::STEP_H0 : ufp_pkg::STEP_D0;
      end else if (emit) begin
        busy <= !last;
        step <= step + 4'd1;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
